>>> rtl/srrle_pkg.sv
`default_nettype none

package srrle_pkg;

   // Largest frame dimension that the decoder honours.
   localparam int MAX_DIM = 256;

   localparam int BYTE_W   = 8;
   localparam int DIM_W    = 9;
   localparam int STRIDE_W = 13;
   localparam int ADDR_W   = 20;
   localparam int COUNT_W  = 6;
   localparam int SKIP_W   = 7;
   localparam int PROD_W   = DIM_W + STRIDE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = STRIDE_W;

   // Run byte flags.
   localparam logic [BYTE_W-1:0] FLAG_SKIP   = 8'h80;
   localparam logic [BYTE_W-1:0] FLAG_REPEAT = 8'h40;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE   = 2'd2;

   localparam logic [DIM_W-1:0]    RESET_FRAME_WIDTH  = 9'd1;
   localparam logic [DIM_W-1:0]    RESET_FRAME_HEIGHT = 9'd1;
   localparam logic [STRIDE_W-1:0] RESET_ROW_STRIDE   = 13'd256;

   // Commands from the controller to the datapath; at most one action is set per cycle,
   // frame_clear may accompany any of the byte actions.
   typedef struct packed {
      logic frame_clear;
      logic skip;
      logic load_repeat;
      logic load_literal;
      logic start_repeat;
      logic lit_take;
      logic drop_take;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;
      logic frame_done;
      logic byte_skip;
      logic byte_repeat;
      logic byte_nonzero;
      logic lit_row_end;
      logic lit_one;
      logic rep_cnt_zero;
      logic emit_last;
   } status_type;

   // Width and height are held to 1..MAX_DIM when used.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/sprite_row_rle_decoder_core.sv
// Sprite row run-length decoder.
// Requests carry one encoded byte each (req_rle_byte) together with req_frame_start, which
// marks the first byte of a frame and returns row, column and decoding state to their start.
// Each pixel written comes out as one result on the rsp_ channel: the buffer address
// (row * stride + column), the palette index and a flag on the last pixel that a byte causes.
// Frame width, frame height and row stride are set through the csr_ write port; the user
// must write them only while idle, which the block does not enforce. A literal's pixel is
// in the output register from the accepting edge on; a repeat run's pixels come from the
// ST_EMIT state. Unless the receiver stalls, run, skip and literal bytes go at one per
// cycle, so literal pixels stream at one per cycle; a repeat colour byte holds off requests
// while the shared output register writes out the N pixels of the clipped run, one a cycle.
// A request is taken while a result waits only if that result is being taken in the same
// cycle. When the receiver stalls, the result holds and requests are stalled in turn.
// Reset clears the decoding state, empties the output register and loads the registers
// with width 1, height 1 and stride 256; no clearing pass is needed.
`default_nettype none

module sprite_row_rle_decoder_core
   import srrle_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_rle_byte,
   input  wire logic                  req_frame_start,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [ADDR_W-1:0]          rsp_pixel_address,
   output logic [BYTE_W-1:0]          rsp_color_index,
   output logic                       rsp_run_last,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // The controller sequences the byte phases and repeat runs.
   srrle_controller u_controller (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_frame_start (req_frame_start),
      .req_stall       (req_stall),
      .status          (status),
      .cmd             (cmd)
   );

   // The datapath holds the counters, the registers and the output register.
   srrle_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_rle_byte      (req_rle_byte),
      .req_frame_start   (req_frame_start),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_color_index   (rsp_color_index),
      .rsp_run_last      (rsp_run_last)
   );

   // A request is never taken while a finished pixel is held up by the receiver.
   assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall && rsp_valid && rsp_stall))
      else $error("request accepted while the output register was blocked");

   // The output register is empty in the cycle after reset.
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result shown straight after reset");

   // Within a repeat run the next pixel follows without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid)
      else $error("gap inside a repeat run");

   // Consecutive pixels of a repeat run lie at consecutive addresses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last
         |=> rsp_pixel_address == $past(rsp_pixel_address) + ADDR_W'(1))
      else $error("repeat run address did not step by one");

endmodule

`default_nettype wire

>>> rtl/srrle_datapath.sv
`default_nettype none

module srrle_datapath
   import srrle_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [BYTE_W-1:0]     req_rle_byte,
   input  wire logic                  req_frame_start,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [ADDR_W-1:0]          rsp_pixel_address,
   output logic [BYTE_W-1:0]          rsp_color_index,
   output logic                       rsp_run_last
);

   logic [DIM_W-1:0]    frame_width_ff;
   logic [DIM_W-1:0]    frame_height_ff;
   logic [STRIDE_W-1:0] row_stride_ff;

   logic [DIM_W-1:0]    column_ff, column_in;
   logic [DIM_W-1:0]    row_ff, row_in;
   logic [COUNT_W-1:0]  literals_left_ff, literals_left_in;
   logic [COUNT_W-1:0]  repeat_length_ff, repeat_length_in;
   logic [BYTE_W-1:0]   color_ff;

   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_pixel_address_ff;
   logic [BYTE_W-1:0]   rsp_color_index_ff;
   logic                rsp_run_last_ff;

   logic [DIM_W-1:0]    width_eff;
   logic [DIM_W-1:0]    height_eff;
   logic [DIM_W-1:0]    col_cur;
   logic [DIM_W-1:0]    row_cur;
   logic [DIM_W-1:0]    room;
   logic [DIM_W-1:0]    skip_len;
   logic [DIM_W-1:0]    skip_amt;
   logic [DIM_W-1:0]    rep_cnt;
   logic [DIM_W:0]      col_sum;
   logic                advance;
   logic                pixel_out;
   logic [PROD_W-1:0]   row_base;
   logic [PROD_W-1:0]   addr_sum;

   assign width_eff  = clamp_dim(frame_width_ff);
   assign height_eff = clamp_dim(frame_height_ff);
   assign col_cur    = cmd.frame_clear ? '0 : column_ff;
   assign row_cur    = cmd.frame_clear ? '0 : row_ff;
   assign room       = (col_cur < width_eff) ? (width_eff - col_cur) : '0;
   assign skip_len   = DIM_W'(req_rle_byte[SKIP_W-1:0]);
   assign skip_amt   = (skip_len < room) ? skip_len : room;
   assign rep_cnt    = (DIM_W'(repeat_length_ff) < room) ? DIM_W'(repeat_length_ff) : room;

   assign status.slot_free    = !rsp_valid_ff || !rsp_stall;
   assign status.frame_done   = !req_frame_start && (row_ff >= height_eff);
   assign status.byte_skip    = (req_rle_byte & FLAG_SKIP) != '0;
   assign status.byte_repeat  = (req_rle_byte & FLAG_REPEAT) != '0;
   assign status.byte_nonzero = req_rle_byte != '0;
   assign status.lit_row_end  = ({1'b0, column_ff} + (DIM_W+1)'(1)) >= {1'b0, width_eff};
   assign status.lit_one      = literals_left_ff == COUNT_W'(1);
   assign status.rep_cnt_zero = rep_cnt == '0;
   assign status.emit_last    = repeat_length_ff == COUNT_W'(1);

   // Pixel address is row * stride + column, wrapped to the address width.
   assign row_base  = PROD_W'(row_ff) * PROD_W'(row_stride_ff);
   assign addr_sum  = row_base + PROD_W'(column_ff);
   assign pixel_out = (cmd.lit_take && (room != '0)) || cmd.emit;

   always_comb begin
      column_in        = column_ff;
      row_in           = row_ff;
      literals_left_in = literals_left_ff;
      repeat_length_in = repeat_length_ff;
      col_sum          = {1'b0, column_ff};
      advance          = 1'b0;
      if (cmd.frame_clear) begin
         column_in        = '0;
         row_in           = '0;
         literals_left_in = '0;
         repeat_length_in = '0;
      end
      if (cmd.skip) begin
         col_sum = {1'b0, col_cur} + {1'b0, skip_amt};
         advance = 1'b1;
      end
      if (cmd.load_repeat) begin
         repeat_length_in = req_rle_byte[COUNT_W-1:0];
      end
      if (cmd.load_literal) begin
         literals_left_in = req_rle_byte[COUNT_W-1:0];
      end
      if (cmd.start_repeat) begin
         // The remaining count now holds the clipped run length.
         repeat_length_in = rep_cnt[COUNT_W-1:0];
         advance          = rep_cnt == '0;
      end
      if (cmd.lit_take) begin
         col_sum          = {1'b0, column_ff} + (DIM_W+1)'(room != '0);
         advance          = 1'b1;
         literals_left_in = literals_left_ff - COUNT_W'(1);
      end
      if (cmd.drop_take) begin
         literals_left_in = literals_left_ff - COUNT_W'(1);
      end
      if (cmd.emit) begin
         col_sum          = {1'b0, column_ff} + (DIM_W+1)'(1);
         advance          = 1'b1;
         repeat_length_in = repeat_length_ff - COUNT_W'(1);
      end
      if (advance) begin
         if (col_sum >= {1'b0, width_eff}) begin
            column_in = '0;
            row_in    = row_cur + DIM_W'(1);
         end else begin
            column_in = col_sum[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= RESET_FRAME_WIDTH;
         frame_height_ff  <= RESET_FRAME_HEIGHT;
         row_stride_ff    <= RESET_ROW_STRIDE;
         column_ff        <= '0;
         row_ff           <= '0;
         literals_left_ff <= '0;
         repeat_length_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_write_data[DIM_W-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_write_data[DIM_W-1:0];
               end
               CSR_ROW_STRIDE: begin
                  row_stride_ff <= csr_write_data;
               end
               default: begin
               end
            endcase
         end
         column_ff        <= column_in;
         row_ff           <= row_in;
         literals_left_ff <= literals_left_in;
         repeat_length_ff <= repeat_length_in;
         if (pixel_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_repeat) begin
         color_ff <= req_rle_byte;
      end
      if (pixel_out) begin
         rsp_pixel_address_ff <= addr_sum[ADDR_W-1:0];
         rsp_color_index_ff   <= cmd.emit ? color_ff : req_rle_byte;
         rsp_run_last_ff      <= cmd.emit ? status.emit_last : 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_pixel_address_ff;
   assign rsp_color_index   = rsp_color_index_ff;
   assign rsp_run_last      = rsp_run_last_ff;

endmodule

`default_nettype wire

>>> rtl/srrle_controller.sv
`default_nettype none

module srrle_controller
   import srrle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_frame_start,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_RUN,
      ST_COLOR,
      ST_LIT,
      ST_DROP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   state_type state_eff;
   logic      accept;

   // Requests wait while a repeat run is being written out or the result slot is full.
   assign req_stall = (state_ff == ST_EMIT) || !status.slot_free;
   assign accept    = req_valid && !req_stall;
   assign state_eff = req_frame_start ? ST_RUN : state_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      if (state_ff == ST_EMIT) begin
         if (status.slot_free) begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = ST_RUN;
            end
         end
      end else if (accept) begin
         cmd.frame_clear = req_frame_start;
         state_in        = state_eff;
         if (!status.frame_done) begin
            case (state_eff)
               ST_RUN: begin
                  if (status.byte_skip) begin
                     cmd.skip = 1'b1;
                  end else if (status.byte_repeat) begin
                     cmd.load_repeat = 1'b1;
                     state_in        = ST_COLOR;
                  end else if (status.byte_nonzero) begin
                     cmd.load_literal = 1'b1;
                     state_in         = ST_LIT;
                  end
               end
               ST_COLOR: begin
                  cmd.start_repeat = 1'b1;
                  state_in         = status.rep_cnt_zero ? ST_RUN : ST_EMIT;
               end
               ST_LIT: begin
                  cmd.lit_take = 1'b1;
                  if (status.lit_row_end) begin
                     state_in = status.lit_one ? ST_RUN : ST_DROP;
                  end else if (status.lit_one) begin
                     state_in = ST_RUN;
                  end
               end
               ST_DROP: begin
                  cmd.drop_take = 1'b1;
                  if (status.lit_one) begin
                     state_in = ST_RUN;
                  end
               end
               default: begin
                  state_in = ST_RUN;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb
   import srrle_pkg::*;
();

   // Decoder phases, mirroring what the block is waiting for next.
   typedef enum logic [1:0] {
      EXPECT_RUN,
      EXPECT_COLOUR,
      TAKE_LITERAL,
      DROP_LITERAL
   } decode_phase_type;

   // The register list has three entries; index 3 lies beyond it.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] colour;
      logic              last;
   } pixel_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rle_byte     = '0;
   logic                  req_frame_start  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [ADDR_W-1:0]     rsp_pixel_address;
   logic [BYTE_W-1:0]     rsp_color_index;
   logic                  rsp_run_last;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   sprite_row_rle_decoder_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rle_byte      (req_rle_byte),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_color_index   (rsp_color_index),
      .rsp_run_last      (rsp_run_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the decoder: registers as written, and the decoding state.
   logic [DIM_W-1:0]    width_q  = RESET_FRAME_WIDTH;
   logic [DIM_W-1:0]    height_q = RESET_FRAME_HEIGHT;
   logic [STRIDE_W-1:0] stride_q = RESET_ROW_STRIDE;
   decode_phase_type    phase_q  = EXPECT_RUN;
   logic [DIM_W-1:0]    col_q    = '0;
   logic [DIM_W-1:0]    row_q    = '0;
   logic [COUNT_W-1:0]  lits_q   = '0;
   logic [COUNT_W-1:0]  rep_q    = '0;

   pixel_type pending_pixels[$];

   bit quiet = 1'b0;
   int errors = 0;
   int requests_sent = 0;
   int decoded_bytes = 0;
   int pixels_checked = 0;
   int settings_used = 0;

   // Width and height outside 1..MAX_DIM are held at the nearest end of the range.
   function automatic int unsigned held_dim(logic [DIM_W-1:0] v);
      if (v == '0)
         return 1;
      if (int'(v) > MAX_DIM)
         return MAX_DIM;
      return int'(v);
   endfunction

   function automatic void queue_pixel(int unsigned col, logic [BYTE_W-1:0] colour, logic last);
      pixel_type   p;
      logic [31:0] a;
      a = 32'(row_q) * 32'(stride_q) + 32'(col);
      p.address = a[ADDR_W-1:0];
      p.colour  = colour;
      p.last    = last;
      pending_pixels.push_back(p);
   endfunction

   function automatic bit close_row_if_full();
      if (int'(col_q) >= held_dim(width_q)) begin
         col_q = '0;
         row_q = row_q + DIM_W'(1);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the pixel writes caused by one accepted request.
   function automatic void decode_byte(logic [BYTE_W-1:0] b, logic frame_start);
      int unsigned w;
      int unsigned room;
      int unsigned cnt;
      int unsigned len;
      if (frame_start) begin
         row_q   = '0;
         col_q   = '0;
         phase_q = EXPECT_RUN;
         lits_q  = '0;
         rep_q   = '0;
      end
      // Once the last row is done, bytes are swallowed until the next frame.
      if (int'(row_q) >= held_dim(height_q))
         return;
      decoded_bytes++;
      w    = held_dim(width_q);
      room = (int'(col_q) < w) ? w - int'(col_q) : 0;
      case (phase_q)
         EXPECT_RUN: begin
            if ((b & FLAG_SKIP) != '0) begin
               len   = b[6:0];
               col_q = col_q + DIM_W'((len < room) ? len : room);
               void'(close_row_if_full());
            end else if ((b & FLAG_REPEAT) != '0) begin
               rep_q   = b[COUNT_W-1:0];
               phase_q = EXPECT_COLOUR;
            end else if (b != '0) begin
               lits_q  = b[COUNT_W-1:0];
               phase_q = TAKE_LITERAL;
            end
         end
         EXPECT_COLOUR: begin
            cnt = (rep_q < room) ? rep_q : room;
            for (int i = 0; i < cnt; i++)
               queue_pixel(int'(col_q) + i, b, (i + 1 == cnt));
            col_q = col_q + DIM_W'(cnt);
            void'(close_row_if_full());
            rep_q   = '0;
            phase_q = EXPECT_RUN;
         end
         TAKE_LITERAL: begin
            if (room > 0) begin
               queue_pixel(int'(col_q), b, 1'b1);
               col_q = col_q + DIM_W'(1);
            end
            lits_q = lits_q - COUNT_W'(1);
            // Literal bytes that spill over the row end are eaten, not written.
            if (close_row_if_full())
               phase_q = (lits_q != '0) ? DROP_LITERAL : EXPECT_RUN;
            else if (lits_q == '0)
               phase_q = EXPECT_RUN;
         end
         default: begin
            lits_q = lits_q - COUNT_W'(1);
            if (lits_q == '0)
               phase_q = EXPECT_RUN;
         end
      endcase
   endfunction

   // Receiver side: stalls at random unless a quiet stretch is running.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 20);
   end

   // Each pixel write taken from the block is checked against the oldest prediction.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel write, address %h colour %h last %b",
                     $time, rsp_pixel_address, rsp_color_index, rsp_run_last);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_pixel_address !== want.address) begin
               $display("%0t: pixel_address expected %h got %h",
                        $time, want.address, rsp_pixel_address);
               errors++;
            end
            if (rsp_color_index !== want.colour) begin
               $display("%0t: color_index expected %h got %h",
                        $time, want.colour, rsp_color_index);
               errors++;
            end
            if (rsp_run_last !== want.last) begin
               $display("%0t: run_last expected %b got %b", $time, want.last, rsp_run_last);
               errors++;
            end
         end
      end
   end

   // Sends one request, now and then with a random gap in front of it, and predicts its pixels.
   task automatic put_byte(input logic [BYTE_W-1:0] b, input logic frame_start);
      if (!quiet && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rle_byte    <= b;
      req_frame_start <= frame_start;
      do
         @(posedge clock);
      while (req_stall);
      requests_sent++;
      decode_byte(b, frame_start);
   endtask

   task automatic wait_for_pixels();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  width_q  = data[DIM_W-1:0];
         CSR_FRAME_HEIGHT: height_q = data[DIM_W-1:0];
         CSR_ROW_STRIDE:   stride_q = data;
         default: ;
      endcase
   endtask

   // Registers change only once the decoder has nothing left in flight.
   task automatic set_frame(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                            input logic [CSR_DATA_W-1:0] s);
      wait_for_pixels();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_ROW_STRIDE, s);
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Mostly well-formed runs with random content, some stray bytes and restarts.
   task automatic gen_frame(input int budget);
      int n;
      int pick;
      int len;
      bit first;
      n     = 0;
      first = 1'b1;
      while (n < budget && (first || int'(row_q) < held_dim(height_q))) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            put_byte(BYTE_W'($urandom), first || ($urandom_range(0, 9) == 0));
            n++;
         end else if (pick < 35) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
            put_byte(FLAG_SKIP | BYTE_W'(len), first);
            n++;
         end else if (pick < 65) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
            put_byte(FLAG_REPEAT | BYTE_W'(len), first);
            put_byte(BYTE_W'($urandom), 1'b0);
            n += 2;
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
            put_byte(BYTE_W'(len), first);
            repeat (len) put_byte(BYTE_W'($urandom), 1'b0);
            n += len + 1;
         end
         first = 1'b0;
      end
      // Now and then a byte after the frame is complete, which must be ignored.
      if ($urandom_range(0, 3) == 0)
         put_byte(BYTE_W'($urandom), 1'b0);
   endtask

   // Reset values: a one by one frame, so a repeat is clipped to a single pixel.
   task automatic test_reset_defaults();
      put_byte(FLAG_REPEAT | 8'd5, 1'b0);
      put_byte(8'h9C, 1'b0);
      put_byte(8'h01, 1'b0);
   endtask

   // Every kind of run byte, zero counts, clipping and dropped literals.
   task automatic test_run_kinds();
      // Upper bits of the width data fall outside the register and are lost.
      set_frame(13'h1E08, 13'd2, 13'h1FFF);
      put_byte(FLAG_SKIP, 1'b1);
      put_byte(8'h00, 1'b0);
      put_byte(FLAG_REPEAT, 1'b0);
      put_byte(8'h5A, 1'b0);
      put_byte(FLAG_SKIP | 8'd2, 1'b0);
      put_byte(8'h03, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'h80, 1'b0);
      put_byte(FLAG_REPEAT | 8'h3F, 1'b0);
      put_byte(8'hC3, 1'b0);
      put_byte(FLAG_SKIP | 8'd6, 1'b0);
      put_byte(8'h04, 1'b0);
      put_byte(8'h12, 1'b0);
      put_byte(8'h34, 1'b0);
      put_byte(8'h56, 1'b0);
      put_byte(8'h78, 1'b0);
      put_byte(FLAG_REPEAT | 8'd1, 1'b0);
   endtask

   // Zero width and height, and a frame start landing on a pending literal or colour byte.
   task automatic test_restart_and_clamp();
      set_frame(13'd0, 13'd0, 13'd1);
      put_byte(8'h03, 1'b1);
      put_byte(8'hAB, 1'b0);
      put_byte(8'hCD, 1'b0);
      put_byte(FLAG_REPEAT | 8'd2, 1'b1);
      put_byte(8'h77, 1'b0);
      put_byte(FLAG_REPEAT | 8'd3, 1'b1);
      put_byte(FLAG_SKIP | 8'd1, 1'b1);
      put_byte(8'h01, 1'b0);
   endtask

   task automatic test_random_frames();
      logic [CSR_DATA_W-1:0] w;
      logic [CSR_DATA_W-1:0] h;
      logic [CSR_DATA_W-1:0] s;
      int target;
      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 5))
            0:       w = 13'd0;
            1:       w = 13'd256;
            2:       w = 13'($urandom_range(257, 511));
            default: w = 13'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       h = 13'd0;
            1:       h = 13'($urandom_range(257, 511));
            default: h = 13'($urandom_range(1, 4));
         endcase
         case ($urandom_range(0, 3))
            0:       s = 13'd1;
            1:       s = 13'h1FFF;
            default: s = 13'($urandom_range(1, 8191));
         endcase
         w[CSR_DATA_W-1:DIM_W] = 4'($urandom);
         h[CSR_DATA_W-1:DIM_W] = 4'($urandom);
         // The widest row in one phase and the largest clamped values in the next.
         if (phase == 0) begin
            w = 13'd256;
            h = 13'd1;
            s = 13'd1;
         end else if (phase == 1) begin
            w = 13'h1FFF;
            h = 13'd300;
            s = 13'h1FFF;
         end
         // One phase runs without any idling on either side.
         quiet = (phase == 2);
         set_frame(w, h, s);
         target = decoded_bytes + 15;
         while (decoded_bytes < target)
            gen_frame(20);
      end
      quiet = 1'b0;
   endtask

   // A frame of the full clamped height with a large stride. Skipping down past row 131
   // takes row times stride beyond the address range, so the pixels after that wrap.
   task automatic test_tall_frame_wrap();
      set_frame(13'($urandom_range(1, 3)), 13'h1FF, 13'h1FFF - 13'($urandom_range(0, 200)));
      put_byte(FLAG_SKIP | 8'h7F, 1'b1);
      repeat (131) put_byte(FLAG_SKIP | 8'h7F, 1'b0);
      repeat (30) put_byte(BYTE_W'($urandom), 1'b0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_run_kinds();
      test_restart_and_clamp();
      test_random_frames();
      test_tall_frame_wrap();
      wait_for_pixels();
      repeat (8) @(posedge clock);
      $display("Summary: %0d requests sent, %0d decoded, %0d pixel writes checked,",
               requests_sent, decoded_bytes, pixels_checked);
      $display("Summary: %0d register settings, %0d mismatches.", settings_used, errors);
      if (errors == 0 && pending_pixels.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   // Far beyond the slowest correct run, even with every run at full length.
   initial begin
      #5000000;
      $display("Timeout with %0d pixel writes outstanding.", pending_pixels.size());
      $display("tb: FAIL");
      $finish;
   end

endmodule
